>>> hdl/u2a_pkg.sv
package u2a_pkg;

   localparam int CAP_BITS    = 16;
   localparam int CHAR_BITS   = 7;
   localparam int RUN_CHARS   = 3;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_AFTER_C2,
      MODE_AFTER_C3,
      MODE_AFTER_E2,
      MODE_AFTER_E2X,
      MODE_SKIP
   } u2a_mode_type;

   // One run of output characters caused by one input word, plus an optional terminator.
   typedef struct packed {
      logic [RUN_CHARS-1:0][CHAR_BITS-1:0] chars;
      logic [1:0]                          nchar;
      logic                                term;
   } u2a_run_type;

   localparam logic [7:0] BYTE_C2 = 8'hc2;
   localparam logic [7:0] BYTE_C3 = 8'hc3;
   localparam logic [7:0] BYTE_E2 = 8'he2;

   localparam logic [CHAR_BITS-1:0] CH_SPACE    = 7'h20;
   localparam logic [CHAR_BITS-1:0] CH_DQUOTE   = 7'h22;
   localparam logic [CHAR_BITS-1:0] CH_SQUOTE   = 7'h27;
   localparam logic [CHAR_BITS-1:0] CH_STAR     = 7'h2a;
   localparam logic [CHAR_BITS-1:0] CH_DASH     = 7'h2d;
   localparam logic [CHAR_BITS-1:0] CH_DOT      = 7'h2e;
   localparam logic [CHAR_BITS-1:0] CH_QUESTION = 7'h3f;
   localparam logic [CHAR_BITS-1:0] CH_E        = 7'h45;
   localparam logic [CHAR_BITS-1:0] CH_M        = 7'h4d;
   localparam logic [CHAR_BITS-1:0] CH_R        = 7'h52;
   localparam logic [CHAR_BITS-1:0] CH_T        = 7'h54;
   localparam logic [CHAR_BITS-1:0] CH_U        = 7'h55;
   localparam logic [CHAR_BITS-1:0] CH_O_LOWER  = 7'h6f;
   localparam logic [CHAR_BITS-1:0] CH_NUL      = 7'h00;

   // Latin-1 letters 0xC0..0xFF with their accents stripped.
   localparam logic [0:63][7:0] ACCENT_MAP =
      "AAAAAAACEEEEIIIIDNOOOOO?OUUUUYPsaaaaaaaceeeeiiiidnooooo?ouuuuypy";

   function automatic u2a_run_type one_char(input logic [CHAR_BITS-1:0] c);
      u2a_run_type r;
      r          = '0;
      r.chars[0] = c;
      r.nchar    = 2'd1;
      return r;
   endfunction

   function automatic logic [CHAR_BITS-1:0] map_c2(input logic [7:0] b);
      logic [CHAR_BITS-1:0] c;
      unique case (b)
         8'ha0:        c = CH_SPACE;
         8'hb0:        c = CH_O_LOWER;
         8'hb7:        c = CH_STAR;
         8'hab, 8'hbb: c = CH_DQUOTE;
         default:      c = CH_QUESTION;
      endcase
      return c;
   endfunction

   function automatic logic [CHAR_BITS-1:0] map_c3(input logic [7:0] b);
      logic [7:0] v;
      v = b | 8'h40;
      if (!v[7]) return CH_QUESTION;
      return ACCENT_MAP[v[5:0]][CHAR_BITS-1:0];
   endfunction

   function automatic u2a_run_type map_e2(input logic [7:0] s, input logic [7:0] t);
      u2a_run_type r;
      r = '0;
      if (s == 8'h80 && t >= 8'h90 && t <= 8'h95) begin
         r = one_char(CH_DASH);
      end else if (s == 8'h80 && (t == 8'h98 || t == 8'h99)) begin
         r = one_char(CH_SQUOTE);
      end else if (s == 8'h80 && (t == 8'h9c || t == 8'h9d)) begin
         r = one_char(CH_DQUOTE);
      end else if (s == 8'h80 && t == 8'ha2) begin
         r = one_char(CH_STAR);
      end else if (s == 8'h80 && t == 8'ha6) begin
         r.chars = {CH_DOT, CH_DOT, CH_DOT};
         r.nchar = 2'd3;
      end else if (s == 8'h82 && t == 8'hac) begin
         r.chars = {CH_R, CH_U, CH_E};
         r.nchar = 2'd3;
      end else if (s == 8'h84 && t == 8'ha2) begin
         r.chars = {CH_NUL, CH_M, CH_T};
         r.nchar = 2'd2;
      end else begin
         r = one_char(CH_QUESTION);
      end
      return r;
   endfunction

endpackage

>>> hdl/u2a_channels.sv
interface u2a_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u2a_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       last_of_run;
   logic       is_terminator;

   modport source (output valid, output out_char, output last_of_run,
                   output is_terminator, input ready);
   modport sink (input valid, input out_char, input last_of_run,
                 input is_terminator, output ready);
endinterface

>>> hdl/u2a_front.sv
module u2a_front #(
   parameter int COUNT_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [15:0]          csr_write_data,
   u2a_req_if.sink              req_chan,
   output u2a_pkg::u2a_run_type push_run,
   output logic                 push_valid,
   input  logic                 push_ready
);
   import u2a_pkg::*;

   localparam int LIM_BITS = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 1;

   logic [CAP_BITS-1:0]   capacity_ff, capacity_in;
   u2a_mode_type          mode_ff, mode_in;
   logic [7:0]            held_ff, held_in;
   logic [1:0]            skip_ff, skip_in;
   logic [COUNT_BITS-1:0] used_ff, used_in;

   logic                  fire;
   logic                  closing;
   logic [7:0]            b;
   logic [CAP_BITS-1:0]   cap_m1;
   logic [LIM_BITS-1:0]   cap_ext, cmax_ext, lim, used_ext, room_wide;
   logic [1:0]            room;
   u2a_run_type           text;
   u2a_mode_type          mode_dec;
   logic [7:0]            held_dec;
   logic [1:0]            skip_dec;
   logic [1:0]            n_text;
   logic                  q_add;

   assign b              = req_chan.in_byte;
   assign req_chan.ready = push_ready;
   assign fire           = req_chan.valid && push_ready;
   assign closing        = (b == 8'h00) || req_chan.end_of_string;

   // Characters still allowed in this string, clipped to the longest run.
   always_comb begin
      cap_m1    = capacity_ff - CAP_BITS'(1);
      cap_ext   = LIM_BITS'(cap_m1);
      cmax_ext  = LIM_BITS'({COUNT_BITS{1'b1}});
      lim       = (cap_ext < cmax_ext) ? cap_ext : cmax_ext;
      used_ext  = LIM_BITS'(used_ff);
      room_wide = (capacity_ff != '0 && used_ext < lim) ? (lim - used_ext) : '0;
      room      = (room_wide > LIM_BITS'(3)) ? 2'd3 : room_wide[1:0];
   end

   // Decode of the incoming byte against the current mode.
   always_comb begin
      text     = '0;
      mode_dec = mode_ff;
      held_dec = held_ff;
      skip_dec = skip_ff;
      if (b != 8'h00) begin
         unique case (mode_ff)
            MODE_AFTER_C2: begin
               mode_dec = MODE_IDLE;
               text     = one_char(map_c2(b));
            end
            MODE_AFTER_C3: begin
               mode_dec = MODE_IDLE;
               text     = one_char(map_c3(b));
            end
            MODE_AFTER_E2: begin
               held_dec = b;
               mode_dec = MODE_AFTER_E2X;
            end
            MODE_AFTER_E2X: begin
               mode_dec = MODE_IDLE;
               text     = map_e2(held_ff, b);
               held_dec = 8'h00;
            end
            MODE_SKIP: begin
               skip_dec = skip_ff - 2'd1;
               if (skip_dec == 2'd0) mode_dec = MODE_IDLE;
            end
            default: begin
               mode_dec = MODE_IDLE;
               if (room != 2'd0) begin
                  priority if ((b >= 8'h20 && b <= 8'h7e) || b == 8'h0a) begin
                     text = one_char(b[CHAR_BITS-1:0]);
                  end else if (b == BYTE_C2) begin
                     mode_dec = MODE_AFTER_C2;
                  end else if (b == BYTE_C3) begin
                     mode_dec = MODE_AFTER_C3;
                  end else if (b == BYTE_E2) begin
                     mode_dec = MODE_AFTER_E2;
                  end else begin
                     text = one_char(CH_QUESTION);
                     priority if (b >= 8'hf0) skip_dec = 2'd3;
                     else if (b >= 8'he0)     skip_dec = 2'd2;
                     else if (b >= 8'hc0)     skip_dec = 2'd1;
                     else                     skip_dec = 2'd0;
                     if (skip_dec != 2'd0) mode_dec = MODE_SKIP;
                  end
               end
            end
         endcase
      end
      n_text = (text.nchar < room) ? text.nchar : room;
      // A sequence left open when the string closes gets one '?' if room is left.
      q_add  = closing && room != 2'd0 &&
               (mode_dec == MODE_AFTER_C2 || mode_dec == MODE_AFTER_C3 ||
                mode_dec == MODE_AFTER_E2 || mode_dec == MODE_AFTER_E2X);
   end

   // Next state.
   always_comb begin
      capacity_in = csr_write_enable ? csr_write_data : capacity_ff;
      mode_in     = mode_ff;
      held_in     = held_ff;
      skip_in     = skip_ff;
      used_in     = used_ff;
      if (fire) begin
         if (closing) begin
            mode_in = MODE_IDLE;
            held_in = 8'h00;
            skip_in = 2'd0;
            used_in = '0;
         end else begin
            mode_in = mode_dec;
            held_in = held_dec;
            skip_in = skip_dec;
            used_in = used_ff + COUNT_BITS'(n_text);
         end
      end
   end

   // Outputs toward the queue.
   always_comb begin
      push_run       = '0;
      push_run.chars = text.chars;
      push_run.nchar = n_text;
      if (q_add) begin
         push_run.chars[0] = CH_QUESTION;
         push_run.nchar    = 2'd1;
      end
      push_run.term = closing && capacity_ff != '0;
      push_valid    = fire && (push_run.nchar != 2'd0 || push_run.term);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_BITS'(64);
         mode_ff     <= MODE_IDLE;
         held_ff     <= 8'h00;
         skip_ff     <= 2'd0;
         used_ff     <= '0;
      end else begin
         capacity_ff <= capacity_in;
         mode_ff     <= mode_in;
         held_ff     <= held_in;
         skip_ff     <= skip_in;
         used_ff     <= used_in;
      end
   end

endmodule

>>> hdl/u2a_queue.sv
module u2a_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  u2a_pkg::u2a_run_type push_run,
   input  logic                 push_valid,
   output logic                 push_ready,
   output u2a_pkg::u2a_run_type pop_run,
   output logic                 pop_valid,
   input  logic                 pop_ready
);
   import u2a_pkg::*;

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   u2a_run_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = count_ff != COUNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_run    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      count_in = count_ff + COUNT_BITS'(do_push) - COUNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_run;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/u2a_back.sv
module u2a_back (
   input  logic                 clock,
   input  logic                 reset,
   input  u2a_pkg::u2a_run_type pop_run,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   u2a_rsp_if.source            rsp_chan
);
   import u2a_pkg::*;

   u2a_run_type cur_ff, cur_in;
   logic        cur_valid_ff, cur_valid_in;
   logic [1:0]  pos_ff, pos_in;
   logic [2:0]  total;
   logic        last;
   logic        fire;

   assign total     = {1'b0, cur_ff.nchar} + 3'(cur_ff.term);
   assign last      = {1'b0, pos_ff} == (total - 3'd1);
   assign fire      = cur_valid_ff && rsp_chan.ready;
   assign pop_ready = !cur_valid_ff || (fire && last);

   always_comb begin
      rsp_chan.valid         = cur_valid_ff;
      rsp_chan.last_of_run   = last;
      rsp_chan.is_terminator = cur_ff.term && (pos_ff >= cur_ff.nchar);
      if (pos_ff < cur_ff.nchar) begin
         unique case (pos_ff)
            2'd0:    rsp_chan.out_char = cur_ff.chars[0];
            2'd1:    rsp_chan.out_char = cur_ff.chars[1];
            default: rsp_chan.out_char = cur_ff.chars[2];
         endcase
      end else begin
         rsp_chan.out_char = CH_NUL;
      end
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      pos_in       = pos_ff;
      if (pop_ready && pop_valid) begin
         cur_in       = pop_run;
         cur_valid_in = 1'b1;
         pos_in       = 2'd0;
      end else if (fire && last) begin
         cur_valid_in = 1'b0;
      end else if (fire) begin
         pos_in = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      pos_ff <= pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) cur_valid_ff <= 1'b0;
      else       cur_valid_ff <= cur_valid_in;
   end

endmodule

>>> hdl/utf8_to_ascii_transliterator.sv
// Channel   Direction  Word contents
// req_chan  in         in_byte (8), end_of_string (1)
// rsp_chan  out        out_char (7), last_of_run (1), is_terminator (1)
// csr       in         csr_write_enable, csr_write_data (16) = capacity
//
// One input word is taken per cycle while the run queue has room; each word
// yields zero to four result words, delivered one per cycle while rsp_chan
// is ready, from the single output register in the back end.
// Reset is synchronous and active high; capacity returns to 64.
// A stall on rsp_chan fills the two-entry run queue before req_chan.ready drops.
module utf8_to_ascii_transliterator #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   u2a_req_if.sink     req_chan,
   u2a_rsp_if.source   rsp_chan
);
   import u2a_pkg::*;

   // The front end decodes each byte and tracks the character budget; it
   // hands a complete run of characters to the queue in the same cycle.
   u2a_run_type push_run, pop_run;
   logic        push_valid, push_ready;
   logic        pop_valid, pop_ready;

   u2a_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_chan        (req_chan),
      .push_run        (push_run),
      .push_valid      (push_valid),
      .push_ready      (push_ready)
   );

   // The queue decouples decoding from delivery of multi-character runs.
   u2a_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_run  (push_run),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .pop_run   (pop_run),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready)
   );

   // The back end walks through a run one character per word and marks the
   // final word of each run; the next run is loaded as the last one leaves.
   u2a_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_run  (pop_run),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> hdl/u2a_checker.sv
module u2a_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_out_char,
   input logic       rsp_last_of_run,
   input logic       rsp_is_terminator
);

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) &&
      $stable(rsp_last_of_run) && $stable(rsp_is_terminator))
      else $error("result word changed while stalled");

   // The terminator is always a zero and always closes its run.
   a_term_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_terminator |-> rsp_last_of_run && rsp_out_char == 7'h00)
      else $error("terminator word malformed");

   // Every other character is printable or a newline.
   a_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_terminator |->
      (rsp_out_char >= 7'h20 && rsp_out_char <= 7'h7e) || rsp_out_char == 7'h0a)
      else $error("non-printable character emitted");

   // Nothing is offered right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind utf8_to_ascii_transliterator u2a_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_out_char     (rsp_chan.out_char),
   .rsp_last_of_run  (rsp_chan.last_of_run),
   .rsp_is_terminator(rsp_chan.is_terminator)
);

>>> dv/tb.sv
`timescale 1ns / 1ps

import u2a_pkg::*;

localparam int          TALLY_BITS = 16;
localparam int unsigned TALLY_MAX  = (1 << TALLY_BITS) - 1;

typedef struct packed {
   logic [CHAR_BITS-1:0] out_char;
   logic                 last_of_run;
   logic                 is_terminator;
} display_word_type;

// Predicts the display words for each accepted byte and checks them in order.
class transliteration_scoreboard;
   string            accent_strip =
      "AAAAAAACEEEEIIIIDNOOOOO?OUUUUYPsaaaaaaaceeeeiiiidnooooo?ouuuuypy";
   logic [15:0]      capacity;
   u2a_mode_type     mode;
   logic [7:0]       held_byte;
   logic [1:0]       skip_left;
   int unsigned      used;
   display_word_type awaited[$];
   display_word_type run[$];
   int               mismatches;

   function new();
      capacity   = 16'd64;
      mismatches = 0;
      close_string();
   endfunction

   function void close_string();
      mode      = MODE_IDLE;
      held_byte = '0;
      skip_left = '0;
      used      = 0;
   endfunction

   function bit has_room();
      return capacity != 0 && used < TALLY_MAX && used + 1 < capacity;
   endfunction

   function void put_char(logic [CHAR_BITS-1:0] c);
      if (!has_room()) return;
      run.push_back('{out_char: c, last_of_run: 1'b0, is_terminator: 1'b0});
      used++;
   endfunction

   function void put_text(string s);
      byte ch;
      for (int i = 0; i < s.len(); i++) begin
         ch = s[i];
         put_char(ch[CHAR_BITS-1:0]);
      end
   endfunction

   function logic [CHAR_BITS-1:0] c2_char(logic [7:0] b);
      case (b)
         8'ha0:        return CH_SPACE;
         8'hb0:        return CH_O_LOWER;
         8'hb7:        return CH_STAR;
         8'hab, 8'hbb: return CH_DQUOTE;
         default:      return CH_QUESTION;
      endcase
   endfunction

   function logic [CHAR_BITS-1:0] c3_char(logic [7:0] b);
      logic [7:0] v;
      byte        ch;
      v = b | 8'h40;
      if (v < 8'hc0) return CH_QUESTION;
      ch = accent_strip[v - 8'hc0];
      return ch[CHAR_BITS-1:0];
   endfunction

   function void put_punctuation(logic [7:0] s, logic [7:0] t);
      if (s == 8'h80 && t >= 8'h90 && t <= 8'h95) put_char(CH_DASH);
      else if (s == 8'h80 && (t == 8'h98 || t == 8'h99)) put_char(CH_SQUOTE);
      else if (s == 8'h80 && (t == 8'h9c || t == 8'h9d)) put_char(CH_DQUOTE);
      else if (s == 8'h80 && t == 8'ha2) put_char(CH_STAR);
      else if (s == 8'h80 && t == 8'ha6) put_text("...");
      else if (s == 8'h82 && t == 8'hac) put_text("EUR");
      else if (s == 8'h84 && t == 8'ha2) put_text("TM");
      else put_char(CH_QUESTION);
   endfunction

   function void take_lead(logic [7:0] b);
      if (!has_room()) return;
      if ((b >= 8'h20 && b <= 8'h7e) || b == 8'h0a) begin
         put_char(b[CHAR_BITS-1:0]);
         return;
      end
      if (b == BYTE_C2) begin
         mode = MODE_AFTER_C2;
         return;
      end
      if (b == BYTE_C3) begin
         mode = MODE_AFTER_C3;
         return;
      end
      if (b == BYTE_E2) begin
         mode = MODE_AFTER_E2;
         return;
      end
      put_char(CH_QUESTION);
      if (b >= 8'hf0) skip_left = 2'd3;
      else if (b >= 8'he0) skip_left = 2'd2;
      else if (b >= 8'hc0) skip_left = 2'd1;
      else skip_left = 2'd0;
      if (skip_left != 0) mode = MODE_SKIP;
   endfunction

   function void note_word(logic [7:0] b, logic eos);
      display_word_type w;
      run.delete();
      if (b != 0) begin
         case (mode)
            MODE_AFTER_C2: begin
               mode = MODE_IDLE;
               put_char(c2_char(b));
            end
            MODE_AFTER_C3: begin
               mode = MODE_IDLE;
               put_char(c3_char(b));
            end
            MODE_AFTER_E2: begin
               held_byte = b;
               mode      = MODE_AFTER_E2X;
            end
            MODE_AFTER_E2X: begin
               mode = MODE_IDLE;
               put_punctuation(held_byte, b);
               held_byte = '0;
            end
            MODE_SKIP: begin
               skip_left = skip_left - 2'd1;
               if (skip_left == 0) mode = MODE_IDLE;
            end
            default: begin
               mode = MODE_IDLE;
               take_lead(b);
            end
         endcase
      end
      if (b == 0 || eos) begin
         // A sequence cut off by the end of the string still shows as '?' if room is left.
         if (mode == MODE_AFTER_C2 || mode == MODE_AFTER_C3 ||
             mode == MODE_AFTER_E2 || mode == MODE_AFTER_E2X) put_char(CH_QUESTION);
         if (capacity != 0)
            run.push_back('{out_char: CH_NUL, last_of_run: 1'b0, is_terminator: 1'b1});
         close_string();
      end
      foreach (run[i]) begin
         w             = run[i];
         w.last_of_run = (i == run.size() - 1);
         awaited.push_back(w);
      end
   endfunction

   function void check_word(display_word_type got);
      display_word_type want;
      if (awaited.size() == 0) begin
         $error("result word with nothing awaited: out_char %h", got.out_char);
         mismatches++;
         return;
      end
      want = awaited.pop_front();
      if (got.out_char !== want.out_char) begin
         $error("out_char: expected %h, got %h", want.out_char, got.out_char);
         mismatches++;
      end
      if (got.last_of_run !== want.last_of_run) begin
         $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
         mismatches++;
      end
      if (got.is_terminator !== want.is_terminator) begin
         $error("is_terminator: expected %b, got %b", want.is_terminator, got.is_terminator);
         mismatches++;
      end
   endfunction
endclass

module tb;

   // The block has a short pipeline: the run queue plus one output register. A
   // byte that causes no result may still be in flight when the last awaited
   // word has come out, so the bench lets it settle before touching capacity.
   localparam int SETTLE_CYCLES  = 8;
   localparam int TIMEOUT_CYCLES = 300000;
   localparam int HOLD_CYCLES    = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;

   u2a_req_if req_chan ();
   u2a_rsp_if rsp_chan ();

   utf8_to_ascii_transliterator #(
      .COUNT_BITS(TALLY_BITS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan)
   );

   transliteration_scoreboard scoreboard = new();

   // Percent of cycles in which each side idles, changed between phases.
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   // Cycles for which the display side will refuse words; counted down by the
   // receiving process itself.
   int          rsp_hold_left = 0;
   int unsigned items_sent    = 0;
   int unsigned cycle_count   = 0;
   logic [7:0]  string_bytes[$];

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > TIMEOUT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Display side: every accepted word is checked against the oldest
   // prediction at the rising edge, and ready is redrawn at the falling edge.
   initial begin
      display_word_type seen;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            seen.out_char      = rsp_chan.out_char;
            seen.last_of_run   = rsp_chan.last_of_run;
            seen.is_terminator = rsp_chan.is_terminator;
            scoreboard.check_word(seen);
         end
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offers one byte, idling at random first, and returns at the falling edge
   // after the word was taken. Valid stays high into the next word unless that
   // word chooses to idle, so it is never dropped and raised in one step.
   task automatic send_word(input logic [7:0] b, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.in_byte       <= b;
      req_chan.end_of_string <= eos;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      scoreboard.note_word(b, eos);
      items_sent++;
      @(negedge clock);
   endtask

   // Stops offering bytes until every predicted word has been seen, then lets
   // the pipeline settle so that no byte is still being worked on.
   task automatic wait_until_drained();
      req_chan.valid <= 1'b0;
      while (scoreboard.awaited.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Only called with the block drained, at a falling edge.
   task automatic write_capacity(input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      scoreboard.capacity = value;
   endtask

   function automatic logic [7:0] nonzero_byte();
      return 8'($urandom_range(255, 1));
   endfunction

   // Appends one character's worth of UTF-8 to string_bytes. Most tokens are
   // well formed so the decoder gets through its multi-byte states; the rest
   // is stray bytes and unmapped sequences.
   function automatic void add_token();
      int         kind;
      int         follow;
      logic [7:0] lead;
      kind = $urandom_range(99);
      if (kind < 35) begin
         if ($urandom_range(19) == 0) string_bytes.push_back(8'h0a);
         else string_bytes.push_back(8'($urandom_range(8'h7e, 8'h20)));
      end else if (kind < 45) begin
         string_bytes.push_back(BYTE_C2);
         case ($urandom_range(9))
            0:       string_bytes.push_back(8'ha0);
            1:       string_bytes.push_back(8'hb0);
            2:       string_bytes.push_back(8'hb7);
            3:       string_bytes.push_back(8'hab);
            4:       string_bytes.push_back(8'hbb);
            default: string_bytes.push_back(nonzero_byte());
         endcase
      end else if (kind < 57) begin
         string_bytes.push_back(BYTE_C3);
         if ($urandom_range(1) == 0) string_bytes.push_back(8'($urandom_range(8'hbf, 8'h80)));
         else string_bytes.push_back(nonzero_byte());
      end else if (kind < 75) begin
         string_bytes.push_back(BYTE_E2);
         case ($urandom_range(9))
            0: begin
               string_bytes.push_back(8'h80);
               string_bytes.push_back(8'($urandom_range(8'h95, 8'h90)));
            end
            1: begin
               string_bytes.push_back(8'h80);
               string_bytes.push_back($urandom_range(1) ? 8'h98 : 8'h99);
            end
            2: begin
               string_bytes.push_back(8'h80);
               string_bytes.push_back($urandom_range(1) ? 8'h9c : 8'h9d);
            end
            3: begin
               string_bytes.push_back(8'h80);
               string_bytes.push_back(8'ha2);
            end
            4: begin
               string_bytes.push_back(8'h80);
               string_bytes.push_back(8'ha6);
            end
            5: begin
               string_bytes.push_back(8'h82);
               string_bytes.push_back(8'hac);
            end
            6: begin
               string_bytes.push_back(8'h84);
               string_bytes.push_back(8'ha2);
            end
            default: begin
               string_bytes.push_back(nonzero_byte());
               string_bytes.push_back(nonzero_byte());
            end
         endcase
      end else if (kind < 88) begin
         // A lead byte with no mapping, followed by the bytes it swallows.
         do lead = nonzero_byte();
         while ((lead >= 8'h20 && lead <= 8'h7e) || lead == 8'h0a ||
                lead == BYTE_C2 || lead == BYTE_C3 || lead == BYTE_E2);
         string_bytes.push_back(lead);
         follow = lead >= 8'hf0 ? 3 : lead >= 8'he0 ? 2 : lead >= 8'hc0 ? 1 : 0;
         repeat (follow) string_bytes.push_back(nonzero_byte());
      end else begin
         string_bytes.push_back(nonzero_byte());
      end
   endfunction

   // Builds and sends one string. It is usually closed by a zero byte or by
   // the end flag on its last byte; sometimes the last byte is dropped to cut
   // a sequence short, and now and then the string is left open.
   task automatic send_string();
      int close_kind;
      string_bytes.delete();
      repeat ($urandom_range(10, 1)) add_token();
      if (string_bytes.size() > 1 && $urandom_range(9) == 0) void'(string_bytes.pop_back());
      close_kind = $urandom_range(19);
      foreach (string_bytes[i]) begin
         send_word(string_bytes[i],
                   (i == string_bytes.size() - 1) && close_kind < 9);
      end
      if (close_kind >= 9 && close_kind < 16) send_word(8'h00, 1'b0);
      else if (close_kind >= 16 && close_kind < 18) send_word(8'h00, 1'b1);
   endtask

   initial begin
      // Each directed entry is {end_of_string, in_byte}.
      logic [8:0]  directed[$];
      logic [15:0] cap_plan[9];
      int unsigned target;

      directed = '{
         9'h020, 9'h07e, 9'h00a,           // printable extremes and newline
         9'h0c2, 9'h0a0,                   // no-break space
         9'h0c3, 9'h080,                   // accented capital
         9'h0c3, 9'h041,                   // C3 with a byte outside the table
         9'h0e2, 9'h080, 9'h0a6,           // ellipsis, three characters
         9'h0e2, 9'h082, 9'h0ac,           // euro sign
         9'h0e2, 9'h084, 9'h0a2,           // trade mark
         9'h0f0, 9'h09f, 9'h098, 9'h080,   // four-byte lead swallows three
         9'h001,                           // control byte, nothing swallowed
         9'h1c2,                           // end flag on a C2 lead
         9'h000                            // empty string: terminator alone
      };
      cap_plan = '{16'd1, 16'd65535, 16'd7, 16'd2, 16'd0, 16'd12, 16'd64, 16'd4,
                   16'($urandom_range(65535, 3))};

      req_chan.valid         <= 1'b0;
      req_chan.in_byte       <= 8'h00;
      req_chan.end_of_string <= 1'b0;
      csr_write_enable       <= 1'b0;
      csr_write_data         <= 16'd0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words run at the reset capacity of 64.
      foreach (directed[i]) send_word(directed[i][7:0], directed[i][8]);
      wait_until_drained();

      // Capacity shrinks while a C3 sequence is open: its completion finds
      // no room and shows nothing, but the terminator still comes.
      send_word(8'h41, 1'b0);
      send_word(BYTE_C3, 1'b0);
      wait_until_drained();
      write_capacity(16'd2);
      send_word(8'ha9, 1'b0);
      send_word(8'h00, 1'b0);
      wait_until_drained();

      // An ellipsis that only partly fits under the cap is cut short.
      write_capacity(16'd3);
      send_word(8'h58, 1'b0);
      send_word(BYTE_E2, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'ha6, 1'b1);

      // Random strings in three idling phases, each over three capacities.
      for (int p = 0; p < 3; p++) begin
         for (int k = 0; k < 3; k++) begin
            wait_until_drained();
            case (p)
               0: begin
                  send_idle_pct = 20;
                  recv_idle_pct = 46;
               end
               1: begin
                  send_idle_pct = 46;
                  recv_idle_pct = 20;
               end
               default: begin
                  send_idle_pct = 0;
                  recv_idle_pct = 0;
               end
            endcase
            write_capacity(cap_plan[3 * p + k]);
            // With the display refusing words for a long stretch, the sender
            // keeps offering bytes until the run queue fills and input stalls.
            if (p == 2 && k == 0) rsp_hold_left = HOLD_CYCLES;
            target = items_sent + 32;
            while (items_sent < target) send_string();
         end
      end

      wait_until_drained();
      if (scoreboard.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
